// File: rtl/assert_macros.svh
// Assertion macros for the checker module of the blend block.
// Expects a clock named i_clk in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define AOB_ASSERT(lbl, rst, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (rst) prop) \
        else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define AOB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

// File: rtl/aob_pkg.sv
// Shared constants and stage types for the RGBA8888 over-blend pipeline.
// Used by aob_front, aob_div_step and the top level.
package aob_pkg;

    localparam int CH_N      = 3;    // red, green, blue
    localparam int CH_W      = 8;
    localparam int PIX_W     = 32;
    localparam int PROD_W    = 16;   // 8 x 8 product
    localparam int NUM_W     = 25;   // up to 255^3
    localparam int DEN_W     = 16;   // up to 255 * 255
    localparam int QUO_W     = 8;
    localparam int DIV_STEPS = 8;
    localparam int SHIFT_W   = 3;

    localparam logic [CH_W-1:0] CH_MAX       = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // One request in flight through the divider stages
    typedef struct packed {
        logic                            valid;
        logic                            transparent;
        logic [PIX_W-1:0]                bottom;
        logic [DEN_W-1:0]                den;
        logic [CH_N-1:0][NUM_W-1:0]      rem;
        logic [CH_N-1:0][QUO_W-1:0]      quo;
    } t_div_stage;

endpackage

// File: rtl/aob_front.sv
// Front end of the blend pipeline: alpha weights, then numerators and divisor.
// Two register stages; depends on aob_pkg.
module aob_front import aob_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_top,
    input  logic [PIX_W-1:0] i_bottom,
    input  logic             i_ready_next,
    output logic             o_ready,
    output t_div_stage       o_stage
);

    logic                         r1_valid;
    logic                         r1_transparent;
    logic [PIX_W-1:0]             r1_bottom;
    logic [CH_N-1:0][PROD_W-1:0]  r1_ct_at;
    logic [CH_N-1:0][CH_W-1:0]    r1_cb;
    logic [PROD_W-1:0]            r1_wb;
    logic [DEN_W-1:0]             r1_den_t;

    logic [CH_N-1:0][PROD_W-1:0]  n1_ct_at;
    logic [CH_N-1:0][CH_W-1:0]    n1_cb;
    logic [PROD_W-1:0]            n1_wb;
    logic [DEN_W-1:0]             n1_den_t;
    logic [CH_W-1:0]              at;
    logic [CH_W-1:0]              ab;
    logic [CH_W-1:0]              rest;

    logic                         r2_valid;
    t_div_stage                   r2_stage;
    t_div_stage                   n2_stage;

    logic                         ready1;
    logic                         ready2;

    assign ready2  = !r2_valid || i_ready_next;
    assign ready1  = !r1_valid || ready2;
    assign o_ready = ready1;

    // Stage 1: per-channel top weight Ct*At and bottom weight Ab*(255-At)
    always_comb begin
        at       = i_top[CH_W-1:0];
        ab       = i_bottom[CH_W-1:0];
        rest     = CH_MAX - at;
        n1_wb    = PROD_W'(ab) * PROD_W'(rest);
        n1_den_t = (DEN_W'(at) << CH_W) - DEN_W'(at);
        for (int ch = 0; ch < CH_N; ch++) begin
            n1_ct_at[ch] = PROD_W'(i_top[PIX_W-1-CH_W*ch -: CH_W])
                           * PROD_W'(at);
            n1_cb[ch]    = i_bottom[PIX_W-1-CH_W*ch -: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1_transparent <= (i_top[CH_W-1:0] == '0);
            r1_bottom      <= i_bottom;
            r1_ct_at       <= n1_ct_at;
            r1_cb          <= n1_cb;
            r1_wb          <= n1_wb;
            r1_den_t       <= n1_den_t;
        end
    end

    // Stage 2: num = Ct*At*255 + Cb*Ab*(255-At), den = At*255 + Ab*(255-At)
    always_comb begin
        n2_stage             = '0;
        n2_stage.valid       = r1_valid;
        n2_stage.transparent = r1_transparent;
        n2_stage.bottom      = r1_bottom;
        n2_stage.den         = r1_den_t + r1_wb;
        for (int ch = 0; ch < CH_N; ch++) begin
            n2_stage.rem[ch] = NUM_W'({r1_ct_at[ch], 8'h00} - {8'h00, r1_ct_at[ch]})
                             + NUM_W'(24'(r1_cb[ch]) * 24'(r1_wb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2_stage <= n2_stage;
        end
    end

    always_comb begin
        o_stage       = r2_stage;
        o_stage.valid = r2_valid;
    end

endmodule

// File: rtl/aob_div_step.sv
// One restoring-division stage: resolves one quotient bit for all three channels.
// Depends on aob_pkg; the bit position comes in on i_shift.
module aob_div_step import aob_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SHIFT_W-1:0] i_shift,
    input  t_div_stage         i_stage,
    input  logic               i_ready_next,
    output logic               o_ready,
    output t_div_stage         o_stage
);

    logic                  r_valid;
    t_div_stage            r_stage;
    t_div_stage            n_stage;
    logic [NUM_W-1:0]      den_sh;

    assign o_ready = !r_valid || i_ready_next;

    // Subtract the shifted divisor where it fits and set the quotient bit
    always_comb begin
        n_stage = i_stage;
        den_sh  = NUM_W'(i_stage.den) << i_shift;
        for (int ch = 0; ch < CH_N; ch++) begin
            if (i_stage.rem[ch] >= den_sh) begin
                n_stage.rem[ch]          = i_stage.rem[ch] - den_sh;
                n_stage.quo[ch][i_shift] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_stage       = r_stage;
        o_stage.valid = r_valid;
    end

endmodule

// File: rtl/alpha_over_blend_rgba8888.sv
// Channel   Dir  Handshake          Payload
// request   in   i_valid / o_stall  i_top_color, i_bottom_color
// result    out  o_valid / i_stall  o_blended_color, o_top_transparent
//
// One request per cycle while o_stall is low; 2 front stages (weights, sums),
// 8 divider stages (one quotient bit each), 1 output register.
// Each stage holds its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up under i_stall and o_stall rises only
// when every stage is full. Synchronous active-low reset clears valid bits.
// Depends on aob_pkg, aob_front and aob_div_step.
module alpha_over_blend_rgba8888 import aob_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_top_color,
    input  logic [PIX_W-1:0] i_bottom_color,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [PIX_W-1:0] o_blended_color,
    output logic             o_top_transparent
);

    t_div_stage        stg [DIV_STEPS+1];
    logic              rdy [DIV_STEPS+1];
    logic              front_ready;

    logic              r_valid;
    logic [PIX_W-1:0]  r_blended;
    logic              r_transparent;
    logic [PIX_W-1:0]  n_blended;
    t_div_stage        last;

    aob_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_top        (i_top_color),
        .i_bottom     (i_bottom_color),
        .i_ready_next (rdy[0]),
        .o_ready      (front_ready),
        .o_stage      (stg[0])
    );

    assign o_stall = !front_ready;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        aob_div_step u_step (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (SHIFT_W'(DIV_STEPS - 1 - k)),
            .i_stage      (stg[k]),
            .i_ready_next (rdy[k+1]),
            .o_ready      (rdy[k]),
            .o_stage      (stg[k+1])
        );
    end

    assign last           = stg[DIV_STEPS];
    assign rdy[DIV_STEPS] = !r_valid || !i_stall;

    // Pass the bottom pixel through untouched when the top is fully clear, else pack the quotients with opaque alpha
    always_comb begin
        if (last.transparent) begin
            n_blended = last.bottom;
        end else begin
            n_blended = {last.quo[0], last.quo[1], last.quo[2], ALPHA_OPAQUE};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rdy[DIV_STEPS]) begin
            r_valid <= last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[DIV_STEPS]) begin
            r_blended     <= n_blended;
            r_transparent <= last.transparent;
        end
    end

    assign o_valid           = r_valid;
    assign o_blended_color   = r_blended;
    assign o_top_transparent = r_transparent;

endmodule

// File: rtl/aob_chk.sv
// Port-level checker for alpha_over_blend_rgba8888, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module aob_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_top_color,
    input logic [31:0] i_bottom_color,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_blended_color,
    input logic        o_top_transparent
);

    // hold a stalled request
    `AOB_ASSERT(a_in_hold, !i_rst_n, i_valid && o_stall |=> $stable({i_top_color, i_bottom_color}))
    // hold a stalled result
    `AOB_ASSERT(a_out_hold, !i_rst_n, o_valid && i_stall |=> o_valid)
    `AOB_ASSERT(a_out_stable, !i_rst_n, o_valid && i_stall |=> $stable(o_blended_color))
    // a blended result is always opaque
    `AOB_ASSERT(a_opaque, !i_rst_n, o_valid && !o_top_transparent |-> o_blended_color[7:0] == 8'hFF)
    // pipeline drains on reset
    `AOB_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

endmodule

bind alpha_over_blend_rgba8888 aob_chk u_aob_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .i_top_color       (i_top_color),
    .i_bottom_color    (i_bottom_color),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_blended_color   (o_blended_color),
    .o_top_transparent (o_top_transparent)
);
